/* hw/rtl/brle_pkg.sv */
// Shared types and constants of the two-level bitmask RLE encoder.
// Stream codes, encoder state record and result record; no dependencies.
package brle_pkg;

    // Stream codes carried in stream_id
    localparam logic [1:0] STREAM_DATA   = 2'd0;
    localparam logic [1:0] STREAM_MASK   = 2'd1;
    localparam logic [1:0] STREAM_POINTS = 2'd2;

    // Bit positions of the mask and points accumulators
    localparam logic [3:0] POS_START = 4'd7;
    localparam logic [3:0] POS_EMPTY = 4'd8;

    // Results one input item can cause
    localparam int RES_SLOTS = 3;

    typedef struct packed {
        logic       first_seen;
        logic [7:0] prev_byte;
        logic [7:0] mask_acc;
        logic [3:0] mask_pos;
        logic       first_mask;
        logic [7:0] prev_mask;
        logic [7:0] points_acc;
        logic [3:0] points_pos;
    } t_state;

    localparam t_state STATE_RESET = '{
        first_seen: 1'b1,
        prev_byte:  8'd0,
        mask_acc:   8'd0,
        mask_pos:   POS_START,
        first_mask: 1'b1,
        prev_mask:  8'd0,
        points_acc: 8'd0,
        points_pos: POS_START
    };

    typedef struct packed {
        logic [1:0] stream_id;
        logic [7:0] out_byte;
        logic       run_last;
    } t_res;

    typedef t_res [RES_SLOTS-1:0] t_res_vec;

endpackage

/* hw/rtl/brle_if.sv */
// Valid/ready channel interfaces of the encoder: image byte input and
// tagged result output. Uses no package.
interface brle_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_byte;
    logic       end_of_image;

    modport source (output valid, output pixel_byte, output end_of_image, input ready);
    modport sink   (input valid, input pixel_byte, input end_of_image, output ready);
endinterface

interface brle_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] stream_id;
    logic [7:0] out_byte;
    logic       run_last;

    modport source (output valid, output stream_id, output out_byte, output run_last,
                    input ready);
    modport sink   (input valid, input stream_id, input out_byte, input run_last,
                     output ready);
endinterface

/* hw/rtl/brle_step.sv */
// Combinational encoder step: next state and compacted results for one byte.
// Depends on brle_pkg.
module brle_step (
    input  brle_pkg::t_state   i_state,
    input  logic [7:0]         i_pixel_byte,
    input  logic               i_end_of_image,
    output brle_pkg::t_state   o_state,
    output brle_pkg::t_res_vec o_res,
    output logic [1:0]         o_count
);
    import brle_pkg::*;

    always_comb begin
        t_state     ns;
        logic [3:0] mp;
        logic [3:0] pp;
        logic [7:0] macc;
        logic [7:0] mval;
        logic [7:0] pacc;
        logic [7:0] pval;
        logic       fm;
        logic       full;
        logic       fin;
        logic       emit_d;
        logic       emit_m;
        logic       emit_p;
        logic [1:0] m_slot;
        logic [1:0] p_slot;

        ns     = i_state;
        emit_d = 1'b0;
        emit_m = 1'b0;
        emit_p = 1'b0;
        macc   = i_state.mask_acc;

        // Data level: emit on change, the first byte always
        if (i_state.first_seen) begin
            emit_d        = 1'b1;
            ns.first_seen = 1'b0;
            mp            = i_state.mask_pos;
            full          = 1'b0;
        end else begin
            mp = i_state.mask_pos - 4'd1;
            if (i_state.prev_byte != i_pixel_byte) begin
                emit_d = 1'b1;
                macc   = macc | (8'd1 << mp[2:0]);
            end
            full = (mp == 4'd0);
        end
        ns.prev_byte = i_pixel_byte;

        // Mask level: finish a full mask byte, or a partial one at end of image
        fin  = full || (i_end_of_image && mp != POS_EMPTY);
        mval = macc;
        fm   = i_state.first_mask;
        pp   = i_state.points_pos;
        pacc = i_state.points_acc;
        pval = pacc;
        if (fin) begin
            if (fm) begin
                emit_m = 1'b1;
                fm     = 1'b0;
            end else begin
                pp = pp - 4'd1;
                if (i_state.prev_mask != mval) begin
                    emit_m = 1'b1;
                    pacc   = pacc | (8'd1 << pp[2:0]);
                end
                if (pp == 4'd0) begin
                    emit_p = 1'b1;
                    pval   = pacc;
                    pacc   = 8'd0;
                    pp     = POS_EMPTY;
                end
            end
            ns.prev_mask = mval;
        end
        if (full) begin
            macc = 8'd0;
            mp   = POS_EMPTY;
        end
        ns.mask_acc   = macc;
        ns.mask_pos   = mp;
        ns.first_mask = fm;
        ns.points_acc = pacc;
        ns.points_pos = pp;

        // End of image: flush pending points bits, then start a new image
        if (i_end_of_image) begin
            if (!fm && pp != POS_EMPTY) begin
                emit_p = 1'b1;
                pval   = pacc;
            end
            ns = STATE_RESET;
        end

        // Pack results in stream order without gaps
        m_slot = {1'b0, emit_d};
        p_slot = m_slot + {1'b0, emit_m};
        o_res  = '0;
        if (emit_d) begin
            o_res[0] = '{stream_id: STREAM_DATA, out_byte: i_pixel_byte,
                         run_last: !(emit_m || emit_p)};
        end
        if (emit_m) begin
            o_res[m_slot] = '{stream_id: STREAM_MASK, out_byte: mval, run_last: !emit_p};
        end
        if (emit_p) begin
            o_res[p_slot] = '{stream_id: STREAM_POINTS, out_byte: pval, run_last: 1'b1};
        end
        o_count = p_slot + {1'b0, emit_p};
        o_state = ns;
    end

endmodule

/* hw/rtl/bitmask_rle_image_encoder_core.sv */
// Top level of the two-level bitmask RLE image encoder.
// Depends on brle_pkg, brle_if (brle_in_if, brle_out_if) and brle_step.
//
// Usage:
//   i_pix carries image bytes in bitplane scan order; end_of_image marks the
//   last byte of an image and flushes the partial mask and points bytes.
//   o_res carries tagged results (data, mask, points); run_last is set on the
//   last result that an input byte causes. A byte causes zero to three results.
//   Flow: a transfer on i_pix lands in the input register; its results are
//   computed combinationally and loaded into the result register, from which
//   they appear on o_res. Throughput is set by the single output port
//   draining the three-entry result register; bytes that repeat without closing
//   a mask byte pass at one per cycle while no results are pending. The input
//   register takes a new byte in the same cycle that the last pending result leaves.
//   Reset (synchronous, active low) empties both registers and returns the
//   encoder to the start of an image. When o_res stalls, results hold, one
//   byte waits in the input register and i_pix.ready drops.
module bitmask_rle_image_encoder_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    brle_in_if.sink           i_pix,
    brle_out_if.source        o_res
);
    import brle_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_pixel;
    logic       r_in_eoi;

    t_state     r_state;
    t_state     n_state;

    t_res_vec   r_slot;
    t_res_vec   n_slot;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    logic       w_out_xfer;
    logic       w_move;

    brle_step u_step (
        .i_state        (r_state),
        .i_pixel_byte   (r_in_pixel),
        .i_end_of_image (r_in_eoi),
        .o_state        (n_state),
        .o_res          (n_slot),
        .o_count        (n_cnt)
    );

    // Advance the held byte once the result register frees up
    assign w_out_xfer  = o_res.valid && o_res.ready;
    assign w_move      = r_in_valid && ((r_cnt == 2'd0) || (r_cnt == 2'd1 && w_out_xfer));
    assign i_pix.ready = !r_in_valid || w_move;

    // Drive the head result
    assign o_res.valid     = (r_cnt != 2'd0);
    assign o_res.stream_id = r_slot[0].stream_id;
    assign o_res.out_byte  = r_slot[0].out_byte;
    assign o_res.run_last  = r_slot[0].run_last;

    // Control: input valid, result count, encoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_cnt      <= 2'd0;
            r_state    <= STATE_RESET;
        end else begin
            if (i_pix.ready) begin
                r_in_valid <= i_pix.valid;
            end
            if (w_move) begin
                r_cnt   <= n_cnt;
                r_state <= n_state;
            end else if (w_out_xfer) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // Payload: capture input byte, load or shift result slots
    always_ff @(posedge i_clk) begin
        if (i_pix.valid && i_pix.ready) begin
            r_in_pixel <= i_pix.pixel_byte;
            r_in_eoi   <= i_pix.end_of_image;
        end
        if (w_move) begin
            r_slot <= n_slot;
        end else if (w_out_xfer) begin
            r_slot[0] <= r_slot[1];
            r_slot[1] <= r_slot[2];
        end
    end

    // Head result closes its byte's run exactly when it is the last one held
    a_run_last_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != 2'd0) |-> (r_slot[0].run_last == (r_cnt == 2'd1)))
        else $error("run_last does not match pending result count");

    // The first two held results keep stream order data, mask, points
    a_stream_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt >= 2'd2) |-> (r_slot[0].stream_id < r_slot[1].stream_id))
        else $error("result streams out of order");

    // A held byte that cannot advance stays put
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_move) |=> (r_in_valid && $stable(r_in_pixel)
                                     && $stable(r_in_eoi)))
        else $error("held input byte lost or changed");

    // Accumulator positions stay within a byte plus the empty mark
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.mask_pos <= POS_EMPTY) && (r_state.points_pos <= POS_EMPTY))
        else $error("accumulator position out of range");

    // The pending result count changes only on a transfer or a load
    a_slot_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |=> $stable(r_cnt))
        else $error("pending result count changed while stalled");

endmodule
